/* sv/vtcds_pkg.sv */
// Shared types and constants for the vertex-to-cell depth stencil.
package vtcds_pkg;

	localparam int MAX_ROW_WIDTH  = 1024;
	localparam int DEPTH_BITS     = 24;
	localparam int COL_BITS       = $clog2(MAX_ROW_WIDTH);
	localparam int WIDTH_BITS     = 11;
	localparam int CFG_INDEX_BITS = 2;

	typedef logic signed [DEPTH_BITS-1:0] depth_t;

	typedef enum logic [1:0] {
		MODE_MAX  = 2'd0,
		MODE_MIN  = 2'd1,
		MODE_MEAN = 2'd2
	} mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_WINDOW_MODE   = 2'd0,
		CFG_ROW_WIDTH     = 2'd1,
		CFG_MISSING_VALUE = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]            window_mode;
		logic [WIDTH_BITS-1:0] row_width;
		depth_t                missing_value;
	} cfg_t;

	typedef struct packed {
		depth_t cur;
		depth_t lf;
		depth_t up;
		depth_t ul;
		logic   active;
	} win_t;

endpackage

/* sv/vtcds_cfg.sv */
// Configuration registers with row width clamped to the supported range.
module vtcds_cfg import vtcds_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [DEPTH_BITS-1:0]     cfg_data,
	output cfg_t                      cfg
);

	logic [1:0]            window_mode_q;
	logic [WIDTH_BITS-1:0] row_width_q;
	depth_t                missing_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_mode_q   <= MODE_MAX;
			row_width_q     <= WIDTH_BITS'(MAX_ROW_WIDTH);
			missing_value_q <= -DEPTH_BITS'(1022976);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WINDOW_MODE)
				window_mode_q <= cfg_data[1:0];
			if (cfg_index == CFG_ROW_WIDTH)
				row_width_q <= cfg_data[WIDTH_BITS-1:0];
			if (cfg_index == CFG_MISSING_VALUE)
				missing_value_q <= depth_t'(cfg_data);
		end
	end

	always_comb begin
		cfg.window_mode   = window_mode_q;
		cfg.missing_value = missing_value_q;
		// zero acts as one, anything wider than the store as the store width
		if (row_width_q == '0)
			cfg.row_width = WIDTH_BITS'(1);
		else if (row_width_q > WIDTH_BITS'(MAX_ROW_WIDTH))
			cfg.row_width = WIDTH_BITS'(MAX_ROW_WIDTH);
		else
			cfg.row_width = row_width_q;
	end

endmodule

/* sv/vtcds_front.sv */
// Raster position tracking, upper row store and the window gathering stage.
module vtcds_front import vtcds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   accept,
	input  logic   advance,
	input  depth_t vertex_depth,
	input  logic   cell_active,
	input  logic   grid_start,
	output logic   valid_s1,
	output win_t   win_s1
);

	logic [COL_BITS-1:0]   col_q;
	logic [COL_BITS-1:0]   col;
	logic                  first_q;
	logic                  first;
	logic [WIDTH_BITS-1:0] col_inc;
	depth_t                left_q;
	depth_t                ul_q;
	depth_t                mem [MAX_ROW_WIDTH];
	depth_t                rd_s1;
	depth_t                cur_s1;
	depth_t                lf_s1;
	depth_t                up_s1;
	logic                  active_s1;
	logic                  first_s1;
	logic                  col0_s1;

	// a grid start restarts row and column before this vertex is used
	assign col     = grid_start ? '0 : col_q;
	assign first   = grid_start | first_q;
	assign col_inc = WIDTH_BITS'(col) + WIDTH_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			first_q  <= 1'b1;
			left_q   <= '0;
			ul_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				left_q <= vertex_depth;
				if (col_inc >= cfg.row_width) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q   <= col_inc[COL_BITS-1:0];
					first_q <= first;
				end
			end
			// the upper sample of the leaving request is the next one's upper-left
			if (valid_s1 && advance)
				ul_q <= up_s1;
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1    <= vertex_depth;
			lf_s1     <= (col == '0) ? vertex_depth : left_q;
			active_s1 <= cell_active;
			first_s1  <= first;
			col0_s1   <= (col == '0);
		end
	end

	// read old contents, then overwrite with the current sample
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1    <= mem[col];
			mem[col] <= vertex_depth;
		end
	end

	assign up_s1 = first_s1 ? cur_s1 : rd_s1;

	always_comb begin
		win_s1.cur    = cur_s1;
		win_s1.lf     = lf_s1;
		win_s1.up     = up_s1;
		win_s1.ul     = (col0_s1 || first_s1) ? cur_s1 : ul_q;
		win_s1.active = active_s1;
	end

endmodule

/* sv/vtcds_window.sv */
// Window reduction (max, min or floored mean), missing-value substitution for inactive cells and the result register.
module vtcds_window import vtcds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   valid_s1,
	input  win_t   win_s1,
	input  logic   centre_stall,
	output logic   advance,
	output logic   centre_valid,
	output depth_t centre_depth
);

	depth_t                       max_a;
	depth_t                       max_b;
	depth_t                       min_a;
	depth_t                       min_b;
	logic signed [DEPTH_BITS+1:0] sum;
	depth_t                       res;

	assign max_a = (win_s1.cur > win_s1.lf) ? win_s1.cur : win_s1.lf;
	assign max_b = (win_s1.up > win_s1.ul) ? win_s1.up : win_s1.ul;
	assign min_a = (win_s1.cur < win_s1.lf) ? win_s1.cur : win_s1.lf;
	assign min_b = (win_s1.up < win_s1.ul) ? win_s1.up : win_s1.ul;

	assign sum = (DEPTH_BITS+2)'(win_s1.cur) + (DEPTH_BITS+2)'(win_s1.lf)
	           + (DEPTH_BITS+2)'(win_s1.up) + (DEPTH_BITS+2)'(win_s1.ul);

	always_comb begin
		if (!win_s1.active) begin
			res = cfg.missing_value;
		end else begin
			unique case (cfg.window_mode)
				MODE_MIN:  res = (min_a < min_b) ? min_a : min_b;
				// arithmetic shift floors toward minus infinity
				MODE_MEAN: res = depth_t'(sum[DEPTH_BITS+1:2]);
				default:   res = (max_a > max_b) ? max_a : max_b;
			endcase
		end
	end

	assign advance = !centre_valid || !centre_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			centre_valid <= 1'b0;
		else if (advance)
			centre_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			centre_depth <= res;
	end

endmodule

/* sv/vertex_to_cell_depth_stencil.sv */
// Vertex-to-cell depth stencil: 2x2 max, min or mean over a raster vertex stream.
// Vertices arrive in raster order, one request per cycle, and each gives one
// cell-centre depth via the window stage and the result register; the sustained
// rate is one request per clock with the output free. The previous row lives in a
// single-port store of one entry per column, read and written once per
// request at the same address, so no clearing pass follows reset. Write
// configuration only while the block is idle; row_width must not grow inside
// a grid, or the second row reads store entries that were never written.
module vertex_to_cell_depth_stencil import vtcds_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [DEPTH_BITS-1:0]     cfg_data,
	input  logic                      vertex_valid,
	output logic                      vertex_stall,
	input  depth_t                    vertex_depth,
	input  logic                      cell_active,
	input  logic                      grid_start,
	output logic                      centre_valid,
	input  logic                      centre_stall,
	output depth_t                    centre_depth
);

	cfg_t cfg;
	win_t win_s1;
	logic valid_s1;
	logic advance;
	logic accept;

	assign vertex_stall = valid_s1 && !advance;
	assign accept       = vertex_valid && !vertex_stall;

	vtcds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vtcds_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.advance      (advance),
		.vertex_depth (vertex_depth),
		.cell_active  (cell_active),
		.grid_start   (grid_start),
		.valid_s1     (valid_s1),
		.win_s1       (win_s1)
	);

	vtcds_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.win_s1       (win_s1),
		.centre_stall (centre_stall),
		.advance      (advance),
		.centre_valid (centre_valid),
		.centre_depth (centre_depth)
	);

endmodule

/* sv/vtcds_checker.sv */
// Port-level checks for the depth stencil, bound to the top level.
module vtcds_checker import vtcds_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [DEPTH_BITS-1:0]     cfg_data,
	input logic                      vertex_valid,
	input logic                      vertex_stall,
	input depth_t                    vertex_depth,
	input logic                      cell_active,
	input logic                      grid_start,
	input logic                      centre_valid,
	input logic                      centre_stall,
	input depth_t                    centre_depth
);

	logic cfg_unused;

	assign cfg_unused = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ (^vertex_depth)
	                  ^ cell_active ^ grid_start;

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		centre_valid && centre_stall |=> centre_valid && $stable(centre_depth))
		else $error("stalled result changed");

	// back-pressure only while the result register is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_stall |-> centre_valid && centre_stall)
		else $error("input stalled with output free");

	// an accepted request is followed by a valid result at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_stall |-> ##2 centre_valid)
		else $error("result missing after accepted request");

	a_known_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(cfg_unused) || !cfg_we)
		else $error("unknown configuration write");

endmodule

bind vertex_to_cell_depth_stencil vtcds_checker u_checker (.*);

/* tb/tb_vertex_to_cell_depth_stencil.sv */
// Self-checking testbench for the vertex-to-cell depth stencil.
module tb_vertex_to_cell_depth_stencil;
	import vtcds_pkg::*;

	localparam int             CYCLE_LIMIT  = 200000;
	localparam int             RANDOM_ITEMS = 390;
	localparam int             WIDTH_TOP    = (1 << WIDTH_BITS) - 1;
	localparam logic [1:0]     MODE_SPARE   = 2'd3;
	localparam depth_t         DEPTH_TOP    = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam depth_t         DEPTH_BOTTOM = {1'b1, {(DEPTH_BITS-1){1'b0}}};

	typedef struct {
		depth_t depth;
		logic   active;
		logic   start;
	} vertex_req_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	cfg_index_t            cfg_index    = CFG_WINDOW_MODE;
	logic [DEPTH_BITS-1:0] cfg_data     = '0;
	logic                  vertex_valid = 1'b0;
	logic                  vertex_stall;
	depth_t                vertex_depth = '0;
	logic                  cell_active  = 1'b0;
	logic                  grid_start   = 1'b0;
	logic                  centre_valid;
	logic                  centre_stall = 1'b0;
	depth_t                centre_depth;

	vertex_req_t vertex_backlog [$];
	depth_t      centre_expected [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	logic        vertex_taken   = 1'b0;
	logic        calm;
	int          gen_width      = MAX_ROW_WIDTH;

	// Stencil state and register copies
	logic [1:0]            mode_q       = MODE_MAX;
	logic [WIDTH_BITS-1:0] row_width_q  = WIDTH_BITS'(MAX_ROW_WIDTH);
	depth_t                missing_q    = depth_t'(-1022976);
	depth_t                upper_row [MAX_ROW_WIDTH];
	depth_t                left_q       = '0;
	depth_t                upper_left_q = '0;
	int unsigned           col_count    = 0;
	logic                  first_row    = 1'b1;

	vertex_to_cell_depth_stencil i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex_depth (vertex_depth),
		.cell_active  (cell_active),
		.grid_start   (grid_start),
		.centre_valid (centre_valid),
		.centre_stall (centre_stall),
		.centre_depth (centre_depth)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign calm = (cycle_count >= 300) && (cycle_count < 700);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic depth_t predict_centre(depth_t cur, logic active, logic start);
		int unsigned                  span;
		int unsigned                  col;
		depth_t                       corners [4];
		depth_t                       res;
		logic signed [DEPTH_BITS+1:0] corner_sum;
		span = (row_width_q == 0) ? 1 :
		       (row_width_q > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width_q;
		if (start) begin
			col_count = 0;
			first_row = 1'b1;
		end
		col = col_count % MAX_ROW_WIDTH;
		corners[0] = cur;
		corners[1] = (col == 0) ? cur : left_q;
		corners[2] = first_row ? cur : upper_row[col];
		corners[3] = (col == 0 || first_row) ? cur : upper_left_q;
		res = cur;
		if (!active) begin
			res = missing_q;
		end else if (mode_q == MODE_MEAN) begin
			corner_sum = corners[0] + corners[1] + corners[2] + corners[3];
			res = depth_t'(corner_sum >>> 2);
		end else begin
			// the spare mode code behaves as maximum
			foreach (corners[k])
				if (mode_q == MODE_MIN ? corners[k] < res : corners[k] > res)
					res = corners[k];
		end
		upper_left_q   = corners[2];
		upper_row[col] = cur;
		left_q         = cur;
		col_count      = col + 1;
		if (col_count >= span) begin
			col_count = 0;
			first_row = 1'b0;
		end
		return res;
	endfunction

	// Monitor: track register writes, predict accepted requests, check results
	always @(posedge clk or negedge arst_n) begin
		depth_t want;
		if (!arst_n) begin
			vertex_taken = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_MODE:   mode_q = cfg_data[1:0];
					CFG_ROW_WIDTH:     row_width_q = cfg_data[WIDTH_BITS-1:0];
					CFG_MISSING_VALUE: missing_q = depth_t'(cfg_data);
					default: ;
				endcase
			end
			vertex_taken = vertex_valid && !vertex_stall;
			if (vertex_taken)
				centre_expected.push_back(predict_centre(vertex_depth, cell_active, grid_start));
			if (centre_valid && !centre_stall) begin
				if (centre_expected.size() == 0) begin
					$display("%0t: centre_depth %0d arrived, expected none", $time,
						centre_depth);
					mismatch_count++;
				end else begin
					want = centre_expected.pop_front();
					if (centre_depth !== want) begin
						$display("%0t: centre_depth expected %0d, got %0d", $time, want,
							centre_depth);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Driver: hold a request until taken, then offer the next or idle
	always @(negedge clk) begin
		vertex_req_t req;
		logic        idle;
		if (arst_n && (!vertex_valid || vertex_taken)) begin
			idle = !calm && ($urandom_range(0, 99) < 29);
			if (vertex_backlog.size() != 0 && !idle) begin
				req = vertex_backlog.pop_front();
				vertex_valid <= 1'b1;
				vertex_depth <= req.depth;
				cell_active  <= req.active;
				grid_start   <= req.start;
			end else begin
				vertex_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		centre_stall <= !calm && ($urandom_range(0, 99) < 29);

	task automatic push_vertex(depth_t d, logic a, logic s);
		vertex_req_t req;
		req.depth  = d;
		req.active = a;
		req.start  = s;
		vertex_backlog.push_back(req);
	endtask

	function automatic depth_t random_depth();
		case ($urandom_range(0, 9))
			0:       return DEPTH_TOP;
			1:       return DEPTH_BOTTOM;
			2, 3:    return depth_t'(int'($urandom_range(0, 64)) - 32);
			default: return depth_t'($urandom());
		endcase
	endfunction

	task automatic queue_random(int count, logic open_grid);
		for (int n = 0; n < count; n++)
			push_vertex(random_depth(), $urandom_range(0, 99) < 85,
				(n == 0) ? open_grid : ($urandom_range(0, 49) == 0));
	endtask

	task automatic drain();
		while (vertex_backlog.size() != 0 || vertex_valid || centre_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(cfg_index_t idx, logic [DEPTH_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Write registers once idle; unused upper data bits carry noise
	task automatic configure(logic wr_mode, logic [1:0] mode, logic wr_width, int width,
			logic wr_miss, depth_t miss);
		logic [DEPTH_BITS-1:0] data;
		drain();
		if (wr_mode) begin
			data      = DEPTH_BITS'($urandom());
			data[1:0] = mode;
			set_reg(CFG_WINDOW_MODE, data);
		end
		if (wr_width) begin
			data                   = DEPTH_BITS'($urandom());
			data[WIDTH_BITS-1:0]   = width[WIDTH_BITS-1:0];
			set_reg(CFG_ROW_WIDTH, data);
			gen_width = (width == 0) ? 1 : (width > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : width;
		end
		if (wr_miss)
			set_reg(CFG_MISSING_VALUE, miss);
	endtask

	initial begin
		int   random_items;
		int   old_width;
		int   count;
		int   width;
		logic open_grid;
		random_items = 0;
		foreach (upper_row[k])
			upper_row[k] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, no grid start yet
		push_vertex(DEPTH_TOP, 1'b1, 1'b0);
		push_vertex(DEPTH_BOTTOM, 1'b1, 1'b0);
		push_vertex(depth_t'(0), 1'b0, 1'b0);
		push_vertex(depth_t'(12345), 1'b1, 1'b0);

		configure(1'b1, MODE_MIN, 1'b1, 2, 1'b1, DEPTH_TOP);
		push_vertex(DEPTH_TOP, 1'b1, 1'b1);
		push_vertex(DEPTH_BOTTOM, 1'b1, 1'b0);
		push_vertex(depth_t'(5), 1'b1, 1'b0);
		push_vertex(DEPTH_TOP, 1'b0, 1'b0);

		// mean at both extremes and rounding of negative sums
		configure(1'b1, MODE_MEAN, 1'b1, 2, 1'b1, DEPTH_BOTTOM);
		repeat (4) push_vertex(DEPTH_BOTTOM, 1'b1, 1'b0);
		push_vertex(DEPTH_TOP, 1'b1, 1'b1);
		repeat (3) push_vertex(DEPTH_TOP, 1'b1, 1'b0);
		push_vertex(depth_t'(-1), 1'b1, 1'b1);
		push_vertex(depth_t'(-2), 1'b1, 1'b0);
		push_vertex(depth_t'(-3), 1'b1, 1'b0);
		push_vertex(depth_t'(-5), 1'b0, 1'b0);

		// spare mode and zero row width
		configure(1'b1, MODE_SPARE, 1'b1, 0, 1'b1, depth_t'(0));
		push_vertex(depth_t'(7), 1'b1, 1'b1);
		push_vertex(depth_t'(-9), 1'b1, 1'b0);
		push_vertex(depth_t'(3), 1'b1, 1'b0);

		// oversized row width clamps to the store depth
		configure(1'b1, 2'($urandom_range(0, 3)), 1'b1,
			$urandom_range(MAX_ROW_WIDTH + 1, WIDTH_TOP), 1'b1, random_depth());
		queue_random(40, 1'b1);

		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:          width = 0;
				1, 2, 3, 4,
				5, 6:       width = $urandom_range(1, 8);
				default:    width = $urandom_range(9, 48);
			endcase
			old_width = gen_width;
			configure($urandom_range(0, 9) < 7, 2'($urandom_range(0, 3)),
				$urandom_range(0, 9) < 7, width, $urandom_range(0, 9) < 7, random_depth());
			// a row no wider than before may carry on inside the current grid
			open_grid = !(gen_width <= old_width && $urandom_range(0, 3) == 0);
			count = gen_width * $urandom_range(1, 4) + $urandom_range(0, 5);
			if (count > 60)
				count = 60;
			queue_random(count, open_grid);
			random_items += count;
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* vertex_to_cell_depth_stencil.f */
sv/vtcds_pkg.sv
sv/vtcds_cfg.sv
sv/vtcds_front.sv
sv/vtcds_window.sv
sv/vertex_to_cell_depth_stencil.sv
sv/vtcds_checker.sv
tb/tb_vertex_to_cell_depth_stencil.sv
